FILE: hdl/canonical_kmer_counting_table_core_macros.svh
// Assertion macros shared by the counting table RTL.
// They sample on clk and are disabled while arst_n is low.
`ifndef CANONICAL_KMER_COUNTING_TABLE_CORE_MACROS_SVH
`define CANONICAL_KMER_COUNTING_TABLE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CKCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CKCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ckct_pkg.sv
package ckct_pkg;

	// Configuration register indexes (bit 2 of the byte address).
	localparam logic REG_KMER_LEN     = 1'b0;
	localparam logic REG_BUCKET_COUNT = 1'b1;

	localparam int KMER_LEN_W     = 5;
	localparam int BUCKET_COUNT_W = 17;

	localparam logic [KMER_LEN_W-1:0]     KMER_LEN_RESET     = 5'd16;
	localparam logic [BUCKET_COUNT_W-1:0] BUCKET_COUNT_RESET = 17'd65536;

	localparam int BASE_W   = 3;
	localparam int CANON_W  = 32;
	localparam int BUCKET_W = 16;
	localparam int COUNT_W  = 32;

	// Kind of result held for the output register.
	typedef enum logic [1:0] {
		RES_NONE,
		RES_HIT,
		RES_FULL
	} res_kind_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      accept;
		logic      div_step;
		logic      probe_init;
		logic      mem_rd;
		logic      probe_next;
		logic      mem_wr;
		logic      emit;
		res_kind_t kind;
	} ckct_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic kmer_ready;
		logic div_done;
		logic probe_hit;
		logic probe_last;
		logic clear_busy;
	} ckct_status_t;

endpackage

FILE: hdl/ckct_base_if.sv
interface ckct_base_if;
	logic                        valid;
	logic                        ready;
	logic [ckct_pkg::BASE_W-1:0] base;
	logic                        seq_start;

	modport source (output valid, output base, output seq_start, input ready);
	modport sink (input valid, input base, input seq_start, output ready);
endinterface

FILE: hdl/ckct_result_if.sv
interface ckct_result_if;
	logic                          valid;
	logic                          ready;
	logic                          kmer_valid;
	logic [ckct_pkg::CANON_W-1:0]  canonical_kmer;
	logic [ckct_pkg::BUCKET_W-1:0] bucket;
	logic [ckct_pkg::COUNT_W-1:0]  occurrence_count;
	logic                          table_full;

	modport source (output valid, output kmer_valid, output canonical_kmer, output bucket,
		output occurrence_count, output table_full, input ready);
	modport sink (input valid, input kmer_valid, input canonical_kmer, input bucket,
		input occurrence_count, input table_full, output ready);
endinterface

FILE: hdl/ckct_ctrl.sv
module ckct_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   out_ready,
	output logic                   out_valid,
	input  ckct_pkg::ckct_status_t status,
	output ckct_pkg::ckct_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV,
		ST_RD,
		ST_CHK,
		ST_UPD,
		ST_EMIT
	} state_t;

	state_t              state_q;
	ckct_pkg::res_kind_t kind_q;
	logic                out_valid_q;
	logic                out_free;

	assign in_ready  = (state_q == ST_IDLE) && !status.clear_busy;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd            = '0;
		cmd.kind       = kind_q;
		cmd.accept     = in_valid && in_ready;
		case (state_q)
			ST_DIV: begin
				cmd.div_step   = !status.div_done;
				cmd.probe_init = status.div_done;
			end
			ST_RD: begin
				cmd.mem_rd = 1'b1;
			end
			ST_CHK: begin
				cmd.probe_next = !status.probe_hit && !status.probe_last;
			end
			ST_UPD: begin
				cmd.mem_wr = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= ckct_pkg::RES_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (status.kmer_ready) begin
						state_q <= ST_DIV;
					end else begin
						kind_q  <= ckct_pkg::RES_NONE;
						state_q <= ST_EMIT;
					end
				end
				ST_DIV: begin
					if (status.div_done) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (status.probe_hit) begin
						state_q <= ST_UPD;
					end else if (status.probe_last) begin
						kind_q  <= ckct_pkg::RES_FULL;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_UPD: begin
					kind_q  <= ckct_pkg::RES_HIT;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/ckct_dp.sv
module ckct_dp #(
	parameter int TABLE_DEPTH = 65536,
	parameter int MAX_K       = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [$clog2(MAX_K+1)-1:0]          k_eff,
	input  logic [$clog2(TABLE_DEPTH):0]        nb,
	input  logic [ckct_pkg::BASE_W-1:0]         base,
	input  logic                                seq_start,
	input  ckct_pkg::ckct_cmd_t                 cmd,
	output ckct_pkg::ckct_status_t              status,
	output logic                                kmer_valid,
	output logic [ckct_pkg::CANON_W-1:0]        canonical_kmer,
	output logic [ckct_pkg::BUCKET_W-1:0]       bucket,
	output logic [ckct_pkg::COUNT_W-1:0]        occurrence_count,
	output logic                                table_full
);

	localparam int KW     = 2 * MAX_K;
	localparam int KLW    = $clog2(MAX_K + 1);
	localparam int SHW    = $clog2(KW + 1);
	localparam int IDXW   = $clog2(TABLE_DEPTH);
	localparam int NBW    = IDXW + 1;
	localparam int SW     = IDXW + 2;
	localparam int DIGITS = (KW + 3) / 4;
	localparam int KWP    = DIGITS * 4;
	localparam int CW     = $clog2(DIGITS + 1);
	localparam int MW     = ckct_pkg::COUNT_W + 1;

	// Sliding window.
	logic [KW-1:0]  fwd_q;
	logic [KW-1:0]  rev_q;
	logic [KLW-1:0] seen_q;
	logic           kmer_q;
	logic [KW-1:0]  canon_q;

	// Remainder unit.
	logic [KWP-1:0]  num_q;
	logic [IDXW-1:0] rem_q;
	logic [CW-1:0]   cnt_q;

	// Probe state.
	logic [IDXW-1:0] i_q;
	logic [IDXW-1:0] first_q;
	logic [IDXW-1:0] d_q;
	logic [ckct_pkg::COUNT_W-1:0] res_count_q;

	// Table storage and clearing sweep.
	logic [MW-1:0]   meta_mem [TABLE_DEPTH];
	logic [KW-1:0]   key_mem  [TABLE_DEPTH];
	logic [MW-1:0]   meta_rd_q;
	logic [KW-1:0]   key_rd_q;
	logic            clr_busy_q;
	logic [IDXW-1:0] clr_addr_q;

	// Output register payload.
	logic                          kmer_valid_q;
	logic [ckct_pkg::CANON_W-1:0]  canon_out_q;
	logic [ckct_pkg::BUCKET_W-1:0] bucket_q;
	logic [ckct_pkg::COUNT_W-1:0]  count_out_q;
	logic                          full_q;

	// Window next-state logic.
	logic [KW-1:0]  mask;
	logic [1:0]     b2;
	logic           is_n;
	logic           restart;
	logic [KW-1:0]  fwd_base;
	logic [KW-1:0]  rev_base;
	logic [KLW-1:0] seen_base;
	logic [KW-1:0]  fwd_n;
	logic [KW-1:0]  rev_n;
	logic [KLW-1:0] seen_n;
	logic           kmer_n;
	logic [KW-1:0]  canon_n;
	logic [SHW-1:0] twice_k;

	always_comb begin
		twice_k   = SHW'({k_eff, 1'b0});
		mask      = {KW{1'b1}} >> (SHW'(KW) - twice_k);
		b2        = base[1:0];
		is_n      = base > ckct_pkg::BASE_W'(3);
		restart   = seq_start || is_n;
		fwd_base  = restart ? '0 : fwd_q;
		rev_base  = restart ? '0 : rev_q;
		seen_base = restart ? '0 : seen_q;
		if (is_n) begin
			fwd_n  = '0;
			rev_n  = '0;
			seen_n = '0;
			kmer_n = 1'b0;
		end else begin
			fwd_n  = ((fwd_base << 2) | KW'(b2)) & mask;
			rev_n  = (((rev_base & mask) >> 2) | (KW'(~b2) << (twice_k - SHW'(2)))) & mask;
			seen_n = (seen_base < k_eff) ? seen_base + KLW'(1) : k_eff;
			kmer_n = (seen_n == k_eff);
		end
		canon_n = (fwd_n < rev_n) ? fwd_n : rev_n;
	end

	// Four restoring remainder steps per cycle.
	logic [NBW-1:0]  r;
	logic [IDXW-1:0] rem_n;

	always_comb begin
		r = {1'b0, rem_q};
		for (int j = 0; j < 4; j++) begin
			r = {r[IDXW-1:0], num_q[KWP-1-j]};
			if (r >= nb) begin
				r = r - nb;
			end
		end
		rem_n = r[IDXW-1:0];
	end

	// Next probe position: (i + 2d + 1) mod nb, the sum stays below 3 * nb.
	logic [SW-1:0]   sum;
	logic [SW-1:0]   t1;
	logic [SW-1:0]   nbx;
	logic [IDXW-1:0] i_next;

	always_comb begin
		nbx    = SW'(nb);
		sum    = SW'(i_q) + SW'({d_q, 1'b1});
		t1     = (sum >= nbx) ? sum - nbx : sum;
		i_next = IDXW'((t1 >= nbx) ? t1 - nbx : t1);
	end

	logic                         rd_valid;
	logic [ckct_pkg::COUNT_W-1:0] rd_count;
	logic [ckct_pkg::COUNT_W-1:0] new_count;

	assign rd_valid  = meta_rd_q[MW-1];
	assign rd_count  = meta_rd_q[ckct_pkg::COUNT_W-1:0];
	assign new_count = (&rd_count) ? rd_count : rd_count + ckct_pkg::COUNT_W'(1);

	assign status.kmer_ready = kmer_q;
	assign status.div_done   = (cnt_q == '0);
	assign status.probe_hit  = !rd_valid || (key_rd_q == canon_q);
	assign status.probe_last = ({1'b0, d_q} == nb - NBW'(1));
	assign status.clear_busy = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q      <= '0;
			rev_q      <= '0;
			seen_q     <= '0;
			kmer_q     <= 1'b0;
			cnt_q      <= '0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + IDXW'(1);
				if (clr_addr_q == IDXW'(TABLE_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cmd.accept) begin
				fwd_q  <= fwd_n;
				rev_q  <= rev_n;
				seen_q <= seen_n;
				kmer_q <= kmer_n;
				cnt_q  <= CW'(DIGITS);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			canon_q <= canon_n;
			num_q   <= KWP'(canon_n);
			rem_q   <= '0;
		end else if (cmd.div_step) begin
			num_q <= num_q << 4;
			rem_q <= rem_n;
		end
		if (cmd.probe_init) begin
			i_q     <= rem_q;
			first_q <= rem_q;
			d_q     <= '0;
		end else if (cmd.probe_next) begin
			i_q <= i_next;
			d_q <= d_q + IDXW'(1);
		end
		if (cmd.mem_wr) begin
			res_count_q <= new_count;
		end
		if (cmd.emit) begin
			case (cmd.kind)
				ckct_pkg::RES_HIT: begin
					kmer_valid_q <= 1'b1;
					canon_out_q  <= ckct_pkg::CANON_W'(canon_q);
					bucket_q     <= ckct_pkg::BUCKET_W'(i_q);
					count_out_q  <= res_count_q;
					full_q       <= 1'b0;
				end
				ckct_pkg::RES_FULL: begin
					kmer_valid_q <= 1'b1;
					canon_out_q  <= ckct_pkg::CANON_W'(canon_q);
					bucket_q     <= ckct_pkg::BUCKET_W'(first_q);
					count_out_q  <= '0;
					full_q       <= 1'b1;
				end
				default: begin
					kmer_valid_q <= 1'b0;
					canon_out_q  <= '0;
					bucket_q     <= '0;
					count_out_q  <= '0;
					full_q       <= 1'b0;
				end
			endcase
		end
	end

	// Valid flag and count share one word; the sweep after reset zeroes it.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			meta_mem[clr_addr_q] <= '0;
		end else if (cmd.mem_wr) begin
			meta_mem[i_q] <= {1'b1, new_count};
		end
		if (cmd.mem_rd) begin
			meta_rd_q <= meta_mem[i_q];
		end
	end

	// Keys are written only when a bucket is claimed.
	always_ff @(posedge clk) begin
		if (cmd.mem_wr && !rd_valid) begin
			key_mem[i_q] <= canon_q;
		end
		if (cmd.mem_rd) begin
			key_rd_q <= key_mem[i_q];
		end
	end

	assign kmer_valid       = kmer_valid_q;
	assign canonical_kmer   = canon_out_q;
	assign bucket           = bucket_q;
	assign occurrence_count = count_out_q;
	assign table_full       = full_q;

endmodule

FILE: hdl/canonical_kmer_counting_table_core.sv
// A base that completes no k-mer goes straight to the output register; with a k-mer, the
// remainder unit (4 bits a cycle) picks the first bucket and the probe loop does one table
// read per probe. A new base is taken only after the result of the last one has been
// handed to the output register.
// Reset (arst_n low, asynchronous) empties the window and the registers take their
// defaults; a sweep then clears every bucket of the table before bases are taken.
`include "canonical_kmer_counting_table_core_macros.svh"

module canonical_kmer_counting_table_core #(
	parameter int TABLE_DEPTH = 65536,
	parameter int MAX_K       = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ckct_base_if.sink            bases,
	ckct_result_if.source        results,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int KLW  = $clog2(MAX_K + 1);
	localparam int IDXW = $clog2(TABLE_DEPTH);
	localparam int NBW  = IDXW + 1;

	// The configuration registers hold exactly what was written. Out-of-range
	// values are clamped on the way to the datapath rather than at write time,
	// so a read returns the raw register contents.
	logic [ckct_pkg::KMER_LEN_W-1:0]     kmer_len_q;
	logic [ckct_pkg::BUCKET_COUNT_W-1:0] bucket_count_q;
	logic                                cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_len_q     <= ckct_pkg::KMER_LEN_RESET;
			bucket_count_q <= ckct_pkg::BUCKET_COUNT_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				ckct_pkg::REG_KMER_LEN: begin
					kmer_len_q <= pwdata[ckct_pkg::KMER_LEN_W-1:0];
				end
				ckct_pkg::REG_BUCKET_COUNT: begin
					bucket_count_q <= pwdata[ckct_pkg::BUCKET_COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ckct_pkg::REG_KMER_LEN:     prdata = 32'(kmer_len_q);
			ckct_pkg::REG_BUCKET_COUNT: prdata = 32'(bucket_count_q);
			default:                    prdata = '0;
		endcase
	end

	// Effective k-mer length is 1..MAX_K and the probing modulus is
	// 1..TABLE_DEPTH; zero counts as one in both cases.
	logic [KLW-1:0] k_eff;
	logic [NBW-1:0] nb;

	always_comb begin
		if (kmer_len_q == '0) begin
			k_eff = KLW'(1);
		end else if (32'(kmer_len_q) > 32'(MAX_K)) begin
			k_eff = KLW'(MAX_K);
		end else begin
			k_eff = KLW'(kmer_len_q);
		end
		if (bucket_count_q == '0) begin
			nb = NBW'(1);
		end else if (32'(bucket_count_q) > 32'(TABLE_DEPTH)) begin
			nb = NBW'(TABLE_DEPTH);
		end else begin
			nb = NBW'(bucket_count_q);
		end
	end

	// The controller sequences one base at a time: window update on the input
	// transfer, the remainder that picks the first bucket, the probe loop, the
	// read-modify-write of the bucket and the hand-off to the output register.
	// The output register lets the next base transfer in while a result waits.
	ckct_pkg::ckct_cmd_t    cmd;
	ckct_pkg::ckct_status_t status;

	ckct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bases.valid),
		.in_ready  (bases.ready),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the window, the remainder unit, the probe arithmetic,
	// the table memories with their clearing sweep, and the result payload.
	ckct_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MAX_K       (MAX_K)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.k_eff            (k_eff),
		.nb               (nb),
		.base             (bases.base),
		.seq_start        (bases.seq_start),
		.cmd              (cmd),
		.status           (status),
		.kmer_valid       (results.kmer_valid),
		.canonical_kmer   (results.canonical_kmer),
		.bucket           (results.bucket),
		.occurrence_count (results.occurrence_count),
		.table_full       (results.table_full)
	);

	// No base may transfer in while the table is still being cleared.
	`CKCT_ASSERT_NOW(a_no_accept_in_clear, status.clear_busy, !bases.ready,
		"base taken during clear")

	// After a transfer the block is still busy with that base in the next cycle.
	`CKCT_ASSERT_NEXT(a_busy_after_accept, bases.valid && bases.ready, !bases.ready,
		"ready after take")

	// A full-table result carries a k-mer and a zero count.
	`CKCT_ASSERT_NOW(a_full_fields, results.valid && results.table_full,
		results.kmer_valid && (results.occurrence_count == '0), "bad full result")

	// A result without a k-mer has all other fields zero.
	`CKCT_ASSERT_NOW(a_empty_fields, results.valid && !results.kmer_valid,
		(results.canonical_kmer == '0) && (results.bucket == '0) &&
		!results.table_full && (results.occurrence_count == '0), "bad empty result")

endmodule

FILE: test/canonical_kmer_counting_table_core_tb.sv
module canonical_kmer_counting_table_core_tb;

	localparam int TABLE_DEPTH = 65536;
	localparam int MAX_K       = 16;

	// One base as the sender presents it.
	typedef struct packed {
		logic [ckct_pkg::BASE_W-1:0] code;
		logic                        start;
	} base_item_t;

	// One tally result as the block should report it.
	typedef struct packed {
		logic                          kmer_valid;
		logic [ckct_pkg::CANON_W-1:0]  canon;
		logic [ckct_pkg::BUCKET_W-1:0] bucket;
		logic [ckct_pkg::COUNT_W-1:0]  count;
		logic                          full;
	} tally_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ckct_base_if   base_ch();
	ckct_result_if result_ch();

	canonical_kmer_counting_table_core #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.MAX_K(MAX_K)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.bases(base_ch),
		.results(result_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Bases waiting for the sender, and tallies waiting for the block to report them.
	base_item_t base_queue[$];
	tally_t     due_tallies[$];
	base_item_t drive_item;

	// Idle percentages of the sender and the receiver, changed between stages of the run.
	int src_idle;
	int sink_idle;

	// Shadow of the configuration registers as last written.
	logic [ckct_pkg::KMER_LEN_W-1:0]     cfg_k;
	logic [ckct_pkg::BUCKET_COUNT_W-1:0] cfg_buckets;

	// Our own copy of the rolling window and of the counting table.
	logic [31:0] win_fwd;
	logic [31:0] win_rev;
	int unsigned win_len;
	bit          tbl_used [TABLE_DEPTH];
	bit [31:0]   tbl_key  [TABLE_DEPTH];
	bit [31:0]   tbl_cnt  [TABLE_DEPTH];

	int errors;
	int n_bases;
	int n_kmers;
	int n_full;
	logic [31:0] top_count;

	always #4 clk = ~clk;

	// Works out the tally for one transferred base and queues it. The window is cleared
	// by a sequence start or by any code above T; the k-mer length and bucket count are
	// clamped into their legal ranges before use, as the block does.
	task automatic tally_base(input logic [ckct_pkg::BASE_W-1:0] code, input logic start);
		tally_t      t;
		int unsigned k;
		int unsigned nb;
		int unsigned first;
		int unsigned slot;
		int unsigned d;
		logic [31:0] m;
		logic [31:0] canon;
		bit          hit;
		t = '0;
		n_bases++;
		k = (cfg_k == '0) ? 1 : ((32'(cfg_k) > MAX_K) ? MAX_K : 32'(cfg_k));
		nb = (cfg_buckets == '0) ? 1 :
			((32'(cfg_buckets) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(cfg_buckets));
		m = (2 * k >= 32) ? 32'hFFFF_FFFF : (32'd1 << (2 * k)) - 32'd1;
		if (start || code > 3) begin
			win_fwd = '0;
			win_rev = '0;
			win_len = 0;
		end
		if (code <= 3) begin
			win_fwd = ((win_fwd << 2) | 32'(code)) & m;
			win_rev = ((win_rev & m) >> 2) | ((32'd3 - 32'(code)) << (2 * k - 2));
			win_rev &= m;
			if (win_len < k) win_len++;
			if (win_len > k) win_len = k;
			if (win_len == k) begin
				canon = (win_fwd < win_rev) ? win_fwd : win_rev;
				first = canon % nb;
				slot = first;
				hit = 1'b0;
				// Quadratic probing: step d moves forward by 2d+1 buckets.
				for (d = 0; d < nb; d++) begin
					if (!tbl_used[slot] || tbl_key[slot] == canon) begin
						hit = 1'b1;
						break;
					end
					slot = (slot + 2 * d + 1) % nb;
				end
				t.kmer_valid = 1'b1;
				t.canon = canon;
				n_kmers++;
				if (!hit) begin
					t.bucket = first[ckct_pkg::BUCKET_W-1:0];
					t.full = 1'b1;
					n_full++;
				end else begin
					if (!tbl_used[slot]) begin
						tbl_used[slot] = 1'b1;
						tbl_key[slot] = canon;
					end
					if (tbl_cnt[slot] != 32'hFFFF_FFFF) tbl_cnt[slot]++;
					t.bucket = slot[ckct_pkg::BUCKET_W-1:0];
					t.count = tbl_cnt[slot];
					if (t.count > top_count) top_count = t.count;
				end
			end
		end
		due_tallies.insert(due_tallies.size(), t);
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Driver: a base is presented from the queue and held until its transfer. Each
	// transfer seen at a clock edge is handed to the predictor right away.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_ch.valid <= 1'b0;
		end else begin
			if (base_ch.valid && base_ch.ready)
				tally_base(base_ch.base, base_ch.seq_start);
			if (!base_ch.valid || base_ch.ready) begin
				if (base_queue.size() != 0 && $urandom_range(99) >= src_idle) begin
					drive_item = base_queue.pop_front();
					base_ch.valid <= 1'b1;
					base_ch.base <= drive_item.code;
					base_ch.seq_start <= drive_item.start;
				end else begin
					base_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: every result transfer is matched against the oldest pending tally.
	// The receiver stalls at random by dropping ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (due_tallies.size() == 0) begin
					$display("%0t: result with nothing expected, actual kmer %h bucket %h",
						$time, result_ch.canonical_kmer, result_ch.bucket);
					errors++;
				end else begin
					tally_t want;
					want = due_tallies.pop_front();
					check_field("kmer_valid", want.kmer_valid, result_ch.kmer_valid);
					check_field("canonical_kmer", want.canon, result_ch.canonical_kmer);
					check_field("bucket", want.bucket, result_ch.bucket);
					check_field("occurrence_count", want.count, result_ch.occurrence_count);
					check_field("table_full", want.full, result_ch.table_full);
				end
			end
			result_ch.ready <= ($urandom_range(99) >= sink_idle);
		end
	end

	// One APB transfer: a setup phase, then the access phase held until pready.
	task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Writes a register, then reads it back. Only called while nothing is in flight,
	// so updating the shadow first cannot affect a prediction.
	task automatic cfg_write(input logic idx, input logic [31:0] value);
		logic [31:0] rd;
		logic [31:0] want;
		if (idx == ckct_pkg::REG_KMER_LEN) begin
			cfg_k = value[ckct_pkg::KMER_LEN_W-1:0];
			want = {{(32-ckct_pkg::KMER_LEN_W){1'b0}}, cfg_k};
		end else begin
			cfg_buckets = value[ckct_pkg::BUCKET_COUNT_W-1:0];
			want = {{(32-ckct_pkg::BUCKET_COUNT_W){1'b0}}, cfg_buckets};
		end
		apb_access(1'b1, idx, value, rd);
		apb_access(1'b0, idx, '0, rd);
		check_field("register readback", want, rd);
	endtask

	function automatic void push_base(input logic [ckct_pkg::BASE_W-1:0] code,
		input logic start);
		base_item_t item;
		item.code = code;
		item.start = start;
		base_queue.insert(base_queue.size(), item);
	endfunction

	// Random reads: mostly well-formed sequences of A/C/G/T opened by a start flag,
	// with a sprinkling of N, the unused codes above N, and stray start flags.
	task automatic queue_reads(input int n);
		int left;
		int len;
		int j;
		int roll;
		logic [ckct_pkg::BASE_W-1:0] code;
		left = n;
		while (left > 0) begin
			len = $urandom_range(1, 48);
			for (j = 0; j < len && left > 0; j++) begin
				roll = $urandom_range(99);
				if (roll < 3) code = 3'd4;
				else if (roll < 4) code = 3'($urandom_range(5, 7));
				else code = 3'($urandom_range(0, 3));
				push_base(code, (j == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0));
				left--;
			end
		end
	endtask

	// Waits until the sender has nothing left and every tally has come back, then lets
	// the block finish any trailing work before the registers are touched.
	task automatic settle();
		do @(negedge clk);
		while (base_queue.size() != 0 || base_ch.valid || due_tallies.size() != 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic run_phase(input logic [4:0] k, input logic [16:0] nb, input int n);
		int left;
		int batch;
		cfg_write(ckct_pkg::REG_KMER_LEN, 32'(k));
		cfg_write(ckct_pkg::REG_BUCKET_COUNT, 32'(nb));
		left = n;
		while (left > 0) begin
			batch = (left < 60) ? left : int'($urandom_range(20, 60));
			@(negedge clk);
			queue_reads(batch);
			left -= batch;
			// Now and then the sender holds off until every tally has come back.
			if ($urandom_range(3) == 0) settle();
		end
		settle();
	endtask

	initial begin
		logic [31:0] rd;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		base_ch.valid = 1'b0;
		base_ch.base = '0;
		base_ch.seq_start = 1'b0;
		result_ch.ready = 1'b0;
		errors = 0;
		n_bases = 0;
		n_kmers = 0;
		n_full = 0;
		top_count = '0;
		cfg_k = ckct_pkg::KMER_LEN_RESET;
		cfg_buckets = ckct_pkg::BUCKET_COUNT_RESET;
		win_fwd = '0;
		win_rev = '0;
		win_len = 0;
		src_idle = 36;
		sink_idle = 68;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The registers must come out of reset at their defaults.
		apb_access(1'b0, ckct_pkg::REG_KMER_LEN, '0, rd);
		check_field("kmer_len after reset", {27'd0, ckct_pkg::KMER_LEN_RESET}, rd);
		apb_access(1'b0, ckct_pkg::REG_BUCKET_COUNT, '0, rd);
		check_field("bucket_count after reset", {15'd0, ckct_pkg::BUCKET_COUNT_RESET}, rd);

		// Directed part. Dimers in a three-bucket table: a k-mer and its reverse
		// complement share a key, palindromes, an N and an unused code breaking the
		// window, starts in mid-sequence, and more distinct keys than buckets so that
		// the table fills up.
		cfg_write(ckct_pkg::REG_KMER_LEN, 32'd2);
		cfg_write(ckct_pkg::REG_BUCKET_COUNT, 32'd3);
		@(negedge clk);
		push_base(3'd0, 1'b1);
		push_base(3'd1, 1'b0);
		push_base(3'd2, 1'b0);
		push_base(3'd3, 1'b0);
		push_base(3'd4, 1'b0);
		push_base(3'd1, 1'b0);
		push_base(3'd7, 1'b0);
		push_base(3'd0, 1'b1);
		push_base(3'd3, 1'b0);
		push_base(3'd2, 1'b1);
		push_base(3'd2, 1'b0);
		push_base(3'd2, 1'b0);
		settle();

		// Zero in both registers: treated as a one-base k-mer and a single bucket.
		// The window is left over from above, so the shorter length applies mid-window.
		cfg_write(ckct_pkg::REG_KMER_LEN, 32'd0);
		cfg_write(ckct_pkg::REG_BUCKET_COUNT, 32'd0);
		@(negedge clk);
		push_base(3'd3, 1'b0);
		push_base(3'd0, 1'b0);
		push_base(3'd2, 1'b1);
		push_base(3'd5, 1'b0);
		push_base(3'd1, 1'b0);
		push_base(3'd6, 1'b1);
		settle();

		// All ones in both registers: clamped to the longest k-mer and the full table,
		// with the window growing from its old length.
		cfg_write(ckct_pkg::REG_KMER_LEN, 32'd31);
		cfg_write(ckct_pkg::REG_BUCKET_COUNT, 32'd131071);
		@(negedge clk);
		push_base(3'd0, 1'b0);
		push_base(3'd1, 1'b0);
		push_base(3'd2, 1'b0);
		push_base(3'd3, 1'b0);
		settle();

		// Random part, first with the receiver the slower side.
		run_phase(5'd16, 17'd65536, 120);
		run_phase(5'd1, 17'd1, 40);
		run_phase(5'd4, 17'd7, 80);

		// Then with the sender the slower side.
		@(negedge clk);
		src_idle = 68;
		sink_idle = 36;
		run_phase(5'd3, 17'd64, 120);
		run_phase(5'd8, 17'd1000, 100);
		run_phase(5'($urandom_range(1, 16)), 17'($urandom_range(1, 300)), 80);

		// Finally at full rate on both sides, including out-of-range settings.
		@(negedge clk);
		src_idle = 0;
		sink_idle = 0;
		run_phase($urandom_range(1) ? 5'd0 : 5'($urandom_range(17, 31)),
			$urandom_range(1) ? 17'd0 : 17'($urandom_range(65537, 131071)), 30);
		run_phase(5'($urandom_range(17, 31)), $urandom_range(1) ? 17'd0 : 17'd131071, 30);
		run_phase(5'd5, 17'd65536, 100);

		settle();
		if (due_tallies.size() != 0) begin
			$display("%0t: %0d tallies never reported", $time, due_tallies.size());
			errors++;
		end
		$display("Sent %0d bases, counted %0d k-mers, %0d of them against a full table.",
			n_bases, n_kmers, n_full);
		$display("Highest count seen %0d; k-mer lengths 0..31 and bucket counts 0..131071 used.",
			top_count);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Safety net: the table clear after reset plus the whole run fit well inside this.
	initial begin
		#(8 * 700000);
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ckct_pkg.sv
hdl/ckct_base_if.sv
hdl/ckct_result_if.sv
hdl/ckct_ctrl.sv
hdl/ckct_dp.sv
hdl/canonical_kmer_counting_table_core.sv
test/canonical_kmer_counting_table_core_tb.sv
